/* rtl/z80_alu_flag_unit_assert.svh */
// Assertion macros for the Z80 ALU flag unit.
`ifndef Z80_ALU_FLAG_UNIT_ASSERT_SVH
`define Z80_ALU_FLAG_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define Z80ALU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define Z80ALU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/z80alu_pkg.sv */
// Package: operation codes, word types and helpers for the Z80 ALU flag unit.
package z80alu_pkg;

    typedef enum logic [3:0] {
        CMD_ADC  = 4'd0,
        CMD_SBC  = 4'd1,
        CMD_INC  = 4'd2,
        CMD_DEC  = 4'd3,
        CMD_AND  = 4'd4,
        CMD_OR   = 4'd5,
        CMD_XOR  = 4'd6,
        CMD_RLC  = 4'd7,
        CMD_RRC  = 4'd8,
        CMD_RL   = 4'd9,
        CMD_RR   = 4'd10,
        CMD_SLA  = 4'd11,
        CMD_SRA  = 4'd12,
        CMD_DAA  = 4'd13,
        CMD_SRL  = 4'd14,
        CMD_PASS = 4'd15
    } t_cmd;

    typedef struct packed {
        logic [3:0] cmd;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic       carry_in;
        logic       half_in;
        logic       subtract_in;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] result;
        logic       sign_flag;
        logic       zero_flag;
        logic       half_flag;
        logic       parity_overflow_flag;
        logic       subtract_flag;
        logic       carry_flag;
    } t_alu_out;

    // DAA correction bytes
    localparam logic [7:0] DAA_NONE   = 8'h00;
    localparam logic [7:0] DAA_LO     = 8'h06;
    localparam logic [7:0] DAA_HI     = 8'h60;
    localparam logic [7:0] DAA_BOTH   = 8'h66;
    localparam logic [7:0] DAA_SUB_H  = 8'hfa;
    localparam logic [7:0] DAA_SUB_C  = 8'ha0;
    localparam logic [7:0] DAA_SUB_CH = 8'h9a;

    localparam logic [7:0] INC_OVF = 8'h7f;
    localparam logic [7:0] DEC_OVF = 8'h80;

    function automatic logic even_parity(input logic [7:0] v);
        return ~(^v);
    endfunction

endpackage

/* rtl/z80_alu_flag_unit.sv */
// Top level of the Z80 ALU flag unit: input register, ALU logic, result register.
//
// Usage:
//   Command channel: drive i_word and raise start; the word is taken at the
//   clock edge where start is high and busy is low. busy is always low, so a
//   new word can be issued every cycle.
//   Result channel: o_word is valid for exactly one cycle while o_strobe is
//   high. The receiver has no way to hold it off and must take it then.
// Path: an accepted word passes the input register, then the result register;
//   o_strobe is high while it sits in the result register.
// Throughput: one word per cycle; the ALU logic between the two registers
//   is combinational: an 8-bit add, subtract, logic op, shift or DAA fix plus flag selection.
// Reset: synchronous, active low; clears both valid stages, so no strobe
//   appears for words in flight when reset was asserted.
// The unit keeps no flag state; incoming C, H and N arrive with each word.
`include "z80_alu_flag_unit_assert.svh"

module z80_alu_flag_unit
    import z80alu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_alu_in  i_word,
    output logic     o_strobe,
    output t_alu_out o_word
);

    logic     r_in_vld;
    t_alu_in  r_in;
    logic     r_out_vld;
    t_alu_out r_out;
    t_alu_out n_out;
    logic     accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= accept;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_word;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    z80alu_calc u_calc (
        .i_word (r_in),
        .o_word (n_out)
    );

    assign o_strobe = r_out_vld;
    assign o_word   = r_out;

    `Z80ALU_ASSERT(a_latency, i_clk, i_rst_n, accept |=> ##1 o_strobe, "accepted word lost")
    `Z80ALU_ASSERT(a_no_spurious, i_clk, i_rst_n, o_strobe |-> $past(accept, 2), "strobe without word")
    `Z80ALU_ASSERT(a_zero, i_clk, i_rst_n, o_strobe |-> (o_word.zero_flag == (o_word.result == 8'd0)), "Z flag mismatch")
    `Z80ALU_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !r_in_vld && !o_strobe, "valid after reset")

endmodule

/* rtl/z80alu_daa.sv */
// DAA correction selection from C, H, N and the accumulator nibbles.
module z80alu_daa
    import z80alu_pkg::*;
(
    input  logic [7:0] i_acc,
    input  logic       i_c,
    input  logic       i_h,
    input  logic       i_n,
    output logic [7:0] o_corr,
    output logic       o_cout
);

    logic lo_ok;
    logic hi_lt10;
    logic hi_lt9;

    assign lo_ok   = (i_acc[3:0] < 4'd10);
    assign hi_lt10 = (i_acc[7:4] < 4'd10);
    assign hi_lt9  = (i_acc[7:4] < 4'd9);

    always_comb begin
        o_corr = DAA_NONE;
        o_cout = 1'b0;
        priority if (i_n) begin
            o_cout = i_c;
            unique case ({i_c, i_h})
                2'b00:   o_corr = DAA_NONE;
                2'b01:   o_corr = DAA_SUB_H;
                2'b10:   o_corr = DAA_SUB_C;
                default: o_corr = DAA_SUB_CH;
            endcase
        end else if (i_c) begin
            o_cout = 1'b1;
            o_corr = (i_h || !lo_ok) ? DAA_BOTH : DAA_HI;
        end else if (i_h) begin
            o_cout = !hi_lt10;
            o_corr = hi_lt10 ? DAA_LO : DAA_BOTH;
        end else if (lo_ok) begin
            o_cout = !hi_lt10;
            o_corr = hi_lt10 ? DAA_NONE : DAA_HI;
        end else begin
            o_cout = !hi_lt9;
            o_corr = hi_lt9 ? DAA_LO : DAA_BOTH;
        end
    end

endmodule

/* rtl/z80alu_calc.sv */
// Result byte and flag logic for one ALU word.
module z80alu_calc
    import z80alu_pkg::*;
(
    input  t_alu_in  i_word,
    output t_alu_out o_word
);

    t_cmd       cmd;
    logic [7:0] a;
    logic [7:0] b;
    logic       ci;
    logic [8:0] add_sum;
    logic [4:0] add_nib;
    logic [8:0] sub_dif;
    logic [4:0] sub_nib;
    logic [7:0] daa_corr;
    logic       daa_cout;
    logic [7:0] r;
    logic       h;
    logic       n;
    logic       c;
    logic       pv;
    logic       use_par;

    assign cmd = t_cmd'(i_word.cmd);
    assign a   = i_word.operand_a;
    assign b   = i_word.operand_b;
    assign ci  = i_word.carry_in;

    assign add_sum = {1'b0, a} + {1'b0, b} + {8'd0, ci};
    assign add_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
    // bit 8 / bit 4 of the wrapped difference is the borrow
    assign sub_dif = {1'b0, a} - {1'b0, b} - {8'd0, ci};
    assign sub_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};

    z80alu_daa u_daa (
        .i_acc  (a),
        .i_c    (ci),
        .i_h    (i_word.half_in),
        .i_n    (i_word.subtract_in),
        .o_corr (daa_corr),
        .o_cout (daa_cout)
    );

    always_comb begin
        r       = a;
        h       = 1'b0;
        n       = 1'b0;
        c       = ci;
        pv      = 1'b0;
        use_par = 1'b1;
        unique case (cmd)
            CMD_ADC: begin
                r       = add_sum[7:0];
                h       = add_nib[4];
                pv      = ~(a[7] ^ b[7]) & (a[7] ^ add_sum[7]);
                c       = add_sum[8];
                use_par = 1'b0;
            end
            CMD_SBC: begin
                r       = sub_dif[7:0];
                h       = sub_nib[4];
                pv      = (a[7] ^ b[7]) & (a[7] ^ sub_dif[7]);
                c       = sub_dif[8];
                n       = 1'b1;
                use_par = 1'b0;
            end
            CMD_INC: begin
                r       = a + 8'd1;
                h       = (a[3:0] == 4'hf);
                pv      = (a == INC_OVF);
                use_par = 1'b0;
            end
            CMD_DEC: begin
                r       = a - 8'd1;
                h       = (a[3:0] == 4'h0);
                pv      = (a == DEC_OVF);
                n       = 1'b1;
                use_par = 1'b0;
            end
            CMD_AND: begin
                r = a & b;
                h = 1'b1;
                c = 1'b0;
            end
            CMD_OR: begin
                r = a | b;
                c = 1'b0;
            end
            CMD_XOR: begin
                r = a ^ b;
                c = 1'b0;
            end
            CMD_RLC: begin
                r = {a[6:0], a[7]};
                c = a[7];
            end
            CMD_RRC: begin
                r = {a[0], a[7:1]};
                c = a[0];
            end
            CMD_RL: begin
                r = {a[6:0], ci};
                c = a[7];
            end
            CMD_RR: begin
                r = {ci, a[7:1]};
                c = a[0];
            end
            CMD_SLA: begin
                r = {a[6:0], 1'b0};
                c = a[7];
            end
            CMD_SRA: begin
                r = {a[7], a[7:1]};
                c = a[0];
            end
            CMD_DAA: begin
                r = a + daa_corr;
                c = daa_cout;
                n = i_word.subtract_in;
            end
            CMD_SRL: begin
                r = {1'b0, a[7:1]};
                c = a[0];
            end
            CMD_PASS: begin
                r = a;
            end
            default: begin
                r = a;
            end
        endcase
        if (use_par) begin
            pv = even_parity(r);
        end
    end

    assign o_word.result               = r;
    assign o_word.sign_flag            = r[7];
    assign o_word.zero_flag            = (r == 8'd0);
    assign o_word.half_flag            = h;
    assign o_word.parity_overflow_flag = pv;
    assign o_word.subtract_flag        = n;
    assign o_word.carry_flag           = c;

endmodule

/* verif/z80_alu_flag_unit_checker.sv */
// Checker for the Z80 ALU flag unit: predicts each accepted word and compares the results.
`timescale 1ns / 1ps

module z80_alu_flag_unit_checker
    import z80alu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_alu_in  i_word,
    input  logic     i_strobe,
    input  t_alu_out i_result,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_checked
);

    t_alu_out alu_flags_q[$];
    int       mism_count = 0;
    int       pending    = 0;
    int       checked    = 0;

    assign o_fail_count = mism_count;
    assign o_pending    = pending;
    assign o_checked    = checked;

    // DAA correction byte and carry out
    function automatic logic [8:0] daa_fix(input logic [7:0] acc, input logic c,
                                           input logic h, input logic n);
        logic lo_fix;
        logic hi_fix;
        if (n) begin
            case ({c, h})
                2'b00:   return {c, DAA_NONE};
                2'b01:   return {c, DAA_SUB_H};
                2'b10:   return {c, DAA_SUB_C};
                default: return {c, DAA_SUB_CH};
            endcase
        end
        lo_fix = h || (acc[3:0] > 4'd9);
        // high nibble of 9 only overflows when the low fix carries into it
        hi_fix = c || (acc[7:4] > 4'd9) || (!h && acc[3:0] > 4'd9 && acc[7:4] == 4'd9);
        return {hi_fix, (hi_fix ? 4'h6 : 4'h0), (lo_fix ? 4'h6 : 4'h0)};
    endfunction

    function automatic t_alu_out alu_flags_for(input t_alu_in w);
        t_alu_out   res;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] r;
        logic [8:0] wide;
        logic [4:0] nib;
        logic       c;
        logic       h;
        logic       n;
        logic       pv;
        logic       arith;
        a = w.operand_a;
        b = w.operand_b;
        r = a;
        c = w.carry_in;
        h = 1'b0;
        n = 1'b0;
        pv = 1'b0;
        arith = 1'b0;
        case (t_cmd'(w.cmd))
            CMD_ADC: begin
                wide = a + b + w.carry_in;
                nib = a[3:0] + b[3:0] + w.carry_in;
                r = wide[7:0];
                c = wide[8];
                h = nib[4];
                pv = (a[7] == b[7]) && (r[7] != a[7]);
                arith = 1'b1;
            end
            CMD_SBC: begin
                wide = a - b - w.carry_in;
                nib = a[3:0] - b[3:0] - w.carry_in;
                r = wide[7:0];
                c = wide[8];
                h = nib[4];
                pv = (a[7] != b[7]) && (r[7] != a[7]);
                n = 1'b1;
                arith = 1'b1;
            end
            CMD_INC: begin
                r = a + 8'd1;
                h = (a[3:0] == 4'hf);
                pv = (a == INC_OVF);
                arith = 1'b1;
            end
            CMD_DEC: begin
                r = a - 8'd1;
                h = (a[3:0] == 4'h0);
                pv = (a == DEC_OVF);
                n = 1'b1;
                arith = 1'b1;
            end
            CMD_AND: begin
                r = a & b;
                h = 1'b1;
                c = 1'b0;
            end
            CMD_OR: begin
                r = a | b;
                c = 1'b0;
            end
            CMD_XOR: begin
                r = a ^ b;
                c = 1'b0;
            end
            CMD_RLC: begin
                r = {a[6:0], a[7]};
                c = a[7];
            end
            CMD_RRC: begin
                r = {a[0], a[7:1]};
                c = a[0];
            end
            CMD_RL: begin
                r = {a[6:0], w.carry_in};
                c = a[7];
            end
            CMD_RR: begin
                r = {w.carry_in, a[7:1]};
                c = a[0];
            end
            CMD_SLA: begin
                r = {a[6:0], 1'b0};
                c = a[7];
            end
            CMD_SRA: begin
                r = {a[7], a[7:1]};
                c = a[0];
            end
            CMD_SRL: begin
                r = {1'b0, a[7:1]};
                c = a[0];
            end
            CMD_DAA: begin
                wide = daa_fix(a, w.carry_in, w.half_in, w.subtract_in);
                r = a + wide[7:0];
                c = wide[8];
                n = w.subtract_in;
            end
            default: begin
                // pass: operand_a through, carry untouched
            end
        endcase
        if (!arith)
            pv = ~(^r);
        res.result = r;
        res.sign_flag = r[7];
        res.zero_flag = (r == 8'h00);
        res.half_flag = h;
        res.parity_overflow_flag = pv;
        res.subtract_flag = n;
        res.carry_flag = c;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mism_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_alu_out want;
        if (i_rst_n) begin
            if ($isunknown(i_strobe)) begin
                $error("o_strobe: expected 0 or 1, got %b", i_strobe);
                mism_count++;
            end else if (i_strobe) begin
                if (alu_flags_q.size() == 0) begin
                    $error("result word with no command outstanding: %h", i_result);
                    mism_count++;
                end else begin
                    want = alu_flags_q.pop_front();
                    check_field("result", want.result, i_result.result);
                    check_field("sign_flag", want.sign_flag, i_result.sign_flag);
                    check_field("zero_flag", want.zero_flag, i_result.zero_flag);
                    check_field("half_flag", want.half_flag, i_result.half_flag);
                    check_field("parity_overflow_flag", want.parity_overflow_flag,
                                i_result.parity_overflow_flag);
                    check_field("subtract_flag", want.subtract_flag,
                                i_result.subtract_flag);
                    check_field("carry_flag", want.carry_flag, i_result.carry_flag);
                    checked++;
                end
            end
            if (i_start && !i_busy)
                alu_flags_q.push_back(alu_flags_for(i_word));
        end
        pending = alu_flags_q.size();
    end

endmodule

/* verif/z80_alu_flag_unit_tb.sv */
// Testbench top for the Z80 ALU flag unit: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module z80_alu_flag_unit_tb
    import z80alu_pkg::*;
;

    localparam int N_RANDOM = 1800;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_alu_in  i_word;
    logic     o_strobe;
    t_alu_out o_word;
    int       fail_count;
    int       pending;
    int       checked;
    int       n_directed = 0;
    int       n_random = 0;
    bit       burst = 1'b0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    z80_alu_flag_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_word  (i_word),
        .o_strobe(o_strobe),
        .o_word  (o_word)
    );

    z80_alu_flag_unit_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_word      (i_word),
        .i_strobe    (o_strobe),
        .i_result    (o_word),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    function automatic t_alu_in alu_word(input t_cmd cmd, input logic [7:0] a,
                                         input logic [7:0] b, input logic c,
                                         input logic h, input logic n);
        t_alu_in w;
        w.cmd = cmd;
        w.operand_a = a;
        w.operand_b = b;
        w.carry_in = c;
        w.half_in = h;
        w.subtract_in = n;
        return w;
    endfunction

    // mostly random, sometimes a byte from the corners
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[8] = '{8'h00, 8'hff, 8'h7f, 8'h80, 8'h0f, 8'hf0, 8'h99, 8'h9a};
        if ($urandom_range(0, 7) == 0)
            return corners[$urandom_range(0, 7)];
        return 8'($urandom);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input t_alu_in w);
        start <= 1'b1;
        i_word <= w;
        do
            @(posedge i_clk);
        while (busy);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
        if (n > 0) begin
            start <= 1'b0;
            i_word <= t_alu_in'($urandom);
            repeat (n) @(negedge i_clk);
        end
    endtask

    initial begin
        t_alu_in directed_q[$];
        t_alu_in w;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_word = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_q = '{
            alu_word(CMD_ADC,  8'hff, 8'h01, 1'b0, 1'b0, 1'b0),
            alu_word(CMD_ADC,  8'h7f, 8'h00, 1'b1, 1'b0, 1'b0),
            alu_word(CMD_SBC,  8'h00, 8'h00, 1'b1, 1'b0, 1'b0),
            alu_word(CMD_SBC,  8'h80, 8'h01, 1'b0, 1'b0, 1'b0),
            alu_word(CMD_INC,  8'h7f, 8'h00, 1'b1, 1'b0, 1'b0),
            alu_word(CMD_INC,  8'hff, 8'hff, 1'b0, 1'b0, 1'b0),
            alu_word(CMD_DEC,  8'h80, 8'h00, 1'b0, 1'b0, 1'b0),
            alu_word(CMD_DEC,  8'h00, 8'h00, 1'b1, 1'b0, 1'b0),
            alu_word(CMD_AND,  8'hff, 8'h00, 1'b1, 1'b0, 1'b0),
            alu_word(CMD_OR,   8'h00, 8'h00, 1'b1, 1'b0, 1'b0),
            alu_word(CMD_XOR,  8'ha5, 8'h5a, 1'b1, 1'b0, 1'b0),
            alu_word(CMD_RLC,  8'h80, 8'h00, 1'b0, 1'b0, 1'b0),
            alu_word(CMD_RRC,  8'h01, 8'h00, 1'b0, 1'b0, 1'b0),
            alu_word(CMD_RL,   8'h80, 8'h00, 1'b1, 1'b0, 1'b0),
            alu_word(CMD_RR,   8'h01, 8'h00, 1'b1, 1'b0, 1'b0),
            alu_word(CMD_SLA,  8'hff, 8'h00, 1'b0, 1'b0, 1'b0),
            alu_word(CMD_SRA,  8'h81, 8'h00, 1'b0, 1'b0, 1'b0),
            alu_word(CMD_SRL,  8'hff, 8'h00, 1'b0, 1'b0, 1'b0),
            alu_word(CMD_PASS, 8'h00, 8'hff, 1'b1, 1'b1, 1'b1),
            // decimal adjust, add side then subtract side
            alu_word(CMD_DAA,  8'h9a, 8'h00, 1'b0, 1'b0, 1'b0),
            alu_word(CMD_DAA,  8'h3c, 8'h00, 1'b0, 1'b0, 1'b0),
            alu_word(CMD_DAA,  8'ha2, 8'h00, 1'b0, 1'b1, 1'b0),
            alu_word(CMD_DAA,  8'h15, 8'h00, 1'b1, 1'b0, 1'b0),
            alu_word(CMD_DAA,  8'h1f, 8'h00, 1'b1, 1'b1, 1'b0),
            alu_word(CMD_DAA,  8'h45, 8'h00, 1'b0, 1'b1, 1'b1),
            alu_word(CMD_DAA,  8'h99, 8'h00, 1'b1, 1'b1, 1'b1)
        };
        foreach (directed_q[k]) begin
            send_word(directed_q[k]);
            n_directed++;
        end

        repeat (N_RANDOM) begin
            if (n_random % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            idle_gap();
            w.cmd = 4'($urandom_range(0, 15));
            w.operand_a = pick_byte();
            w.operand_b = pick_byte();
            w.carry_in = 1'($urandom);
            w.half_in = 1'($urandom);
            w.subtract_in = 1'($urandom);
            send_word(w);
            n_random++;
        end
        start <= 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        $display("covered %0d directed and %0d random words over all 16 operation codes",
                 n_directed, n_random);
        $display("%0d result words compared field by field", checked);
        if (fail_count == 0)
            $display("z80_alu_flag_unit: match");
        else
            $display("z80_alu_flag_unit: mismatch");
        $finish;
    end

    initial begin
        #2ms;
        $display("z80_alu_flag_unit: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/z80alu_pkg.sv
rtl/z80alu_daa.sv
rtl/z80alu_calc.sv
rtl/z80_alu_flag_unit.sv
verif/z80_alu_flag_unit_checker.sv
verif/z80_alu_flag_unit_tb.sv
